// File: rtl/core/elbp_pkg.sv
// ----------------------------------------------------------------------------
// elbp_pkg
// shared constants, types and state codes for the edge list to parens block
// ----------------------------------------------------------------------------
package elbp_pkg;

   // open-node stack
   localparam int STACK_DEPTH = 32;
   localparam int NODE_BITS   = 16;
   localparam int FILL_BITS   = $clog2(STACK_DEPTH + 1);
   localparam int IDX_BITS    = $clog2(STACK_DEPTH);

   // bits caused by one edge: pops, push, leaf pair, final pops
   localparam int CNT_BITS = $clog2(2 * STACK_DEPTH + 4);

   // edge queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int TIP_BITS      = 16;
   localparam logic [TIP_BITS-1:0] TIP_COUNT_RESET = TIP_BITS'(1);
   localparam logic REG_TIP_COUNT = 1'b0;

   typedef struct packed {
      logic [NODE_BITS-1:0] parent;
      logic                 leaf;
      logic                 last_edge;
   } elbp_edge_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLIMB,
      ST_EMIT
   } elbp_state_type;

endpackage

// File: rtl/core/edge_list_to_balanced_parens.sv
// ----------------------------------------------------------------------------
// edge_list_to_balanced_parens: an accepted edge passes through the queue, the
// back's edge registers, the climb and emit states and the output register;
// the back plays one bit per cycle while the receiver keeps up, and takes the
// next edge only when idle or as it finishes the bit run of the previous one
// reset: synchronous, clears queue, stack fill, fsm and tip_count to 1
// ----------------------------------------------------------------------------
module edge_list_to_balanced_parens (
   input  logic                               clock,
   input  logic                               reset,
   // edge input
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [elbp_pkg::NODE_BITS-1:0]     req_parent_node,
   input  logic [elbp_pkg::NODE_BITS-1:0]     req_child_node,
   input  logic                               req_final_edge,
   // paren bit output
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_paren_bit,
   output logic                               rsp_run_end,
   output logic                               rsp_stack_fault,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [elbp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [elbp_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [elbp_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   // front side: classified edge into the queue
   logic                    edge_push;
   logic                    edge_full;
   elbp_pkg::elbp_edge_type edge_in;

   // back side: queue head into the stack engine
   logic                    edge_valid;
   logic                    edge_pop;
   elbp_pkg::elbp_edge_type edge_out;

   // front takes edges and marks leaf children against tip_count
   elbp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_parent_node (req_parent_node),
      .req_child_node  (req_child_node),
      .req_final_edge  (req_final_edge),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .edge_push       (edge_push),
      .edge_data       (edge_in),
      .edge_full       (edge_full)
   );

   // queue lets the front keep accepting while long pop runs drain
   elbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (edge_push),
      .push_data (edge_in),
      .full      (edge_full),
      .pop       (edge_pop),
      .valid     (edge_valid),
      .pop_data  (edge_out)
   );

   // back climbs the stack one pop per cycle, then plays out the bit run
   // through its output register; the fault flag is known before the first bit
   elbp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .edge_valid      (edge_valid),
      .edge_data       (edge_out),
      .edge_pop        (edge_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_paren_bit   (rsp_paren_bit),
      .rsp_run_end     (rsp_run_end),
      .rsp_stack_fault (rsp_stack_fault)
   );

endmodule

// File: rtl/core/elbp_front.sv
// ----------------------------------------------------------------------------
// elbp_front
// accepts edges, holds tip_count and tags each edge whose child is a leaf
// ----------------------------------------------------------------------------
module elbp_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [elbp_pkg::NODE_BITS-1:0]       req_parent_node,
   input  logic [elbp_pkg::NODE_BITS-1:0]       req_child_node,
   input  logic                                 req_final_edge,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [elbp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [elbp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [elbp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output logic                                 edge_push,
   output elbp_pkg::elbp_edge_type              edge_data,
   input  logic                                 edge_full
);

   logic [elbp_pkg::TIP_BITS-1:0] tip_count_ff;
   logic [elbp_pkg::TIP_BITS-1:0] tip_count_in;
   logic                          reg_sel;
   logic                          csr_write;

   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[2] == elbp_pkg::REG_TIP_COUNT);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tip_count_in = tip_count_ff;
      if (csr_write && reg_sel) begin
         tip_count_in = csr_pwdata[elbp_pkg::TIP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tip_count_ff <= elbp_pkg::TIP_COUNT_RESET;
      end else begin
         tip_count_ff <= tip_count_in;
      end
   end

   assign csr_prdata = reg_sel ?
      elbp_pkg::CSR_DATA_BITS'(tip_count_ff) : '0;

   // classify: a child at or below tip_count is a leaf
   assign req_ready           = !edge_full;
   assign edge_push           = req_valid && req_ready;
   assign edge_data.parent    = req_parent_node;
   assign edge_data.leaf      = (req_child_node <= tip_count_ff);
   assign edge_data.last_edge = req_final_edge;

endmodule

// File: rtl/core/elbp_queue.sv
// ----------------------------------------------------------------------------
// elbp_queue
// short fifo of classified edges between front and back
// ----------------------------------------------------------------------------
module elbp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  elbp_pkg::elbp_edge_type push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    valid,
   output elbp_pkg::elbp_edge_type pop_data
);

   elbp_pkg::elbp_edge_type          slot_ff [elbp_pkg::QUEUE_DEPTH];
   logic [elbp_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [elbp_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [elbp_pkg::QCNT_BITS-1:0]   count_ff, count_in;
   logic                             do_push, do_pop;

   assign full     = (count_ff == elbp_pkg::QCNT_BITS'(elbp_pkg::QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == elbp_pkg::QPTR_BITS'(elbp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + elbp_pkg::QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == elbp_pkg::QPTR_BITS'(elbp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + elbp_pkg::QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + elbp_pkg::QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - elbp_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/elbp_back.sv
// ----------------------------------------------------------------------------
// elbp_back
// runs the open-node stack for each edge, then plays out its paren bits
// ----------------------------------------------------------------------------
module elbp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    edge_valid,
   input  elbp_pkg::elbp_edge_type edge_data,
   output logic                    edge_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_paren_bit,
   output logic                    rsp_run_end,
   output logic                    rsp_stack_fault
);

   elbp_pkg::elbp_state_type state_ff, state_in;

   logic [elbp_pkg::NODE_BITS-1:0] stack_ff [elbp_pkg::STACK_DEPTH];
   logic [elbp_pkg::FILL_BITS-1:0] fill_ff, fill_in;

   // edge in progress
   logic [elbp_pkg::NODE_BITS-1:0] parent_ff, parent_in;
   logic                           leaf_ff, leaf_in;
   logic                           last_ff, last_in;

   // shape of the bit run
   logic [elbp_pkg::FILL_BITS-1:0] pops_ff, pops_in;
   logic [elbp_pkg::FILL_BITS-1:0] closes_ff, closes_in;
   logic                           push_ff, push_in;
   logic                           fault_ff, fault_in;
   logic [elbp_pkg::CNT_BITS-1:0]  emit_idx_ff, emit_idx_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic paren_ff, paren_in;
   logic run_end_ff, run_end_in;
   logic sfault_ff, sfault_in;

   logic [elbp_pkg::IDX_BITS-1:0]  top_idx;
   logic [elbp_pkg::NODE_BITS-1:0] top;
   logic                           has_top;
   logic                           climb_stop, climb_fault;
   logic                           do_push, overflow, push_ok;
   logic [elbp_pkg::FILL_BITS-1:0] fill_after_push;
   logic [elbp_pkg::CNT_BITS-1:0]  total, push_pos, leaf_pos;
   logic                           empty_run, emit_last, out_free;
   logic                           emit_fire, emit_done, load;
   logic                           climb_step, climb_end, emit_bit;

   assign top_idx = elbp_pkg::IDX_BITS'(fill_ff - elbp_pkg::FILL_BITS'(1));
   assign top     = stack_ff[top_idx];
   assign has_top = (fill_ff != '0);

   // first look: climb only when parent is below top; later: stop on match or empty
   assign climb_stop  = (pops_ff == '0) ? !(has_top && (parent_ff < top))
                                        : (!has_top || (top == parent_ff));
   assign climb_fault = (pops_ff != '0) && !has_top;

   assign do_push         = !has_top || (parent_ff > top);
   assign overflow        = do_push &&
                            (fill_ff == elbp_pkg::FILL_BITS'(elbp_pkg::STACK_DEPTH));
   assign push_ok         = do_push && !overflow;
   assign fill_after_push = fill_ff + elbp_pkg::FILL_BITS'(push_ok);

   assign total = elbp_pkg::CNT_BITS'(pops_ff) + elbp_pkg::CNT_BITS'(push_ff) +
                  (leaf_ff ? elbp_pkg::CNT_BITS'(2) : '0) +
                  elbp_pkg::CNT_BITS'(closes_ff);
   assign push_pos  = elbp_pkg::CNT_BITS'(pops_ff);
   assign leaf_pos  = push_pos + elbp_pkg::CNT_BITS'(push_ff);
   assign empty_run = (total == '0);
   assign emit_last = (emit_idx_ff == total - elbp_pkg::CNT_BITS'(1));
   assign emit_bit  = (push_ff && (emit_idx_ff == push_pos)) ||
                      (leaf_ff && (emit_idx_ff == leaf_pos));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // fsm outputs
   always_comb begin
      climb_step = 1'b0;
      climb_end  = 1'b0;
      emit_fire  = 1'b0;
      emit_done  = 1'b0;
      case (state_ff)
         elbp_pkg::ST_CLIMB: begin
            climb_step = !climb_stop;
            climb_end  = climb_stop;
         end
         elbp_pkg::ST_EMIT: begin
            emit_fire = !empty_run && out_free;
            emit_done = empty_run || (out_free && emit_last);
         end
         default: begin
         end
      endcase
      load = edge_valid && ((state_ff == elbp_pkg::ST_IDLE) || emit_done);
   end

   assign edge_pop = load;

   // fsm next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         elbp_pkg::ST_IDLE: begin
            if (edge_valid) state_in = elbp_pkg::ST_CLIMB;
         end
         elbp_pkg::ST_CLIMB: begin
            if (climb_stop) state_in = elbp_pkg::ST_EMIT;
         end
         elbp_pkg::ST_EMIT: begin
            if (emit_done) state_in = edge_valid ? elbp_pkg::ST_CLIMB : elbp_pkg::ST_IDLE;
         end
         default: state_in = elbp_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      fill_in      = fill_ff;
      parent_in    = parent_ff;
      leaf_in      = leaf_ff;
      last_in      = last_ff;
      pops_in      = pops_ff;
      closes_in    = closes_ff;
      push_in      = push_ff;
      fault_in     = fault_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      paren_in     = paren_ff;
      run_end_in   = run_end_ff;
      sfault_in    = sfault_ff;

      if (load) begin
         parent_in = edge_data.parent;
         leaf_in   = edge_data.leaf;
         last_in   = edge_data.last_edge;
         pops_in   = '0;
      end
      if (climb_step) begin
         fill_in = fill_ff - elbp_pkg::FILL_BITS'(1);
         pops_in = pops_ff + elbp_pkg::FILL_BITS'(1);
      end
      if (climb_end) begin
         push_in     = do_push;
         fault_in    = climb_fault || overflow;
         fill_in     = last_ff ? '0 : fill_after_push;
         closes_in   = last_ff ? fill_after_push : '0;
         emit_idx_in = '0;
      end
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         paren_in     = emit_bit;
         run_end_in   = emit_last;
         sfault_in    = fault_ff;
         emit_idx_in  = emit_idx_ff + elbp_pkg::CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= elbp_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      parent_ff   <= parent_in;
      leaf_ff     <= leaf_in;
      last_ff     <= last_in;
      pops_ff     <= pops_in;
      closes_ff   <= closes_in;
      push_ff     <= push_in;
      fault_ff    <= fault_in;
      emit_idx_ff <= emit_idx_in;
      paren_ff    <= paren_in;
      run_end_ff  <= run_end_in;
      sfault_ff   <= sfault_in;
   end

   always_ff @(posedge clock) begin
      if (climb_end && push_ok) begin
         stack_ff[fill_ff[elbp_pkg::IDX_BITS-1:0]] <= parent_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_paren_bit   = paren_ff;
   assign rsp_run_end     = run_end_ff;
   assign rsp_stack_fault = sfault_ff;

   // stack never holds more than its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= elbp_pkg::FILL_BITS'(elbp_pkg::STACK_DEPTH))
      else $error("stack fill beyond depth");

   // each climb step removes exactly one node
   a_climb_pop: assert property (@(posedge clock) disable iff (reset)
      climb_step |=> fill_ff == $past(fill_ff) - elbp_pkg::FILL_BITS'(1))
      else $error("climb step did not pop one node");

   // a final edge leaves the stack empty
   a_final_empty: assert property (@(posedge clock) disable iff (reset)
      (climb_end && last_ff) |=> fill_ff == '0)
      else $error("final edge left open nodes");

   // no bit is played past the end of the run
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> emit_idx_ff < total)
      else $error("emit index past run length");

endmodule

// File: tb/tb_edge_list_to_balanced_parens.sv
// ----------------------------------------------------------------------------
// tb_edge_list_to_balanced_parens
// drives tree edges into the parens encoder, mirrors the open-node stack in
// a local predictor and checks every emitted bit in order, with random
// sender bursts, receiver stalls and tip_count changes between phases
// ----------------------------------------------------------------------------
module tb_edge_list_to_balanced_parens;

   // timing knobs
   localparam int RESET_CYCLES    = 12;
   localparam int SETTLE_CYCLES   = 40;     // no-output edges may still be in flight
   localparam int DRAIN_LIMIT     = 20000;  // cycles to wait for outstanding bits
   localparam int RSP_HOLD_CYCLES = 300;    // long receiver hold-off

   localparam logic [elbp_pkg::CSR_ADDR_BITS-1:0] TIP_ADDR =
      elbp_pkg::CSR_ADDR_BITS'(4 * elbp_pkg::REG_TIP_COUNT);

   // one emitted bit as seen on the result channel
   typedef struct packed {
      logic paren_bit;
      logic run_end;
      logic stack_fault;
   } paren_bit_type;

   localparam paren_bit_type OPEN_BIT  =
      '{paren_bit: 1'b1, run_end: 1'b0, stack_fault: 1'b0};
   localparam paren_bit_type CLOSE_BIT =
      '{paren_bit: 1'b0, run_end: 1'b0, stack_fault: 1'b0};

   // receiver stall patterns
   typedef enum int {
      RX_ALWAYS,
      RX_COIN,
      RX_RARE_STALL,
      RX_ONE_IN_THREE
   } rx_pattern_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   // block inputs, all known from time zero
   logic                               req_valid       = 1'b0;
   logic [elbp_pkg::NODE_BITS-1:0]     req_parent_node = '0;
   logic [elbp_pkg::NODE_BITS-1:0]     req_child_node  = '0;
   logic                               req_final_edge  = 1'b0;
   logic                               rsp_ready       = 1'b0;
   logic                               csr_psel        = 1'b0;
   logic                               csr_penable     = 1'b0;
   logic                               csr_pwrite      = 1'b0;
   logic [elbp_pkg::CSR_ADDR_BITS-1:0] csr_paddr       = '0;
   logic [elbp_pkg::CSR_DATA_BITS-1:0] csr_pwdata      = '0;

   // block outputs
   logic                               req_ready;
   logic                               rsp_valid;
   logic                               rsp_paren_bit;
   logic                               rsp_run_end;
   logic                               rsp_stack_fault;
   logic [elbp_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   edge_list_to_balanced_parens uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_parent_node (req_parent_node),
      .req_child_node  (req_child_node),
      .req_final_edge  (req_final_edge),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_paren_bit   (rsp_paren_bit),
      .rsp_run_end     (rsp_run_end),
      .rsp_stack_fault (rsp_stack_fault),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // predictor state: shadow of the open-node stack and tip_count
   logic [elbp_pkg::NODE_BITS-1:0] open_stack [elbp_pkg::STACK_DEPTH];
   int                             open_count = 0;
   logic [elbp_pkg::TIP_BITS-1:0]  leaf_limit = elbp_pkg::TIP_COUNT_RESET;

   // bits still owed by the block, oldest first
   paren_bit_type expected_parens [$];

   int  error_count  = 0;
   int  items_sent   = 0;
   int  bits_seen    = 0;

   // sender pacing
   int  burst_left   = 0;
   bit  steady_send  = 1'b0;   // no gaps at all while set

   // receiver hold-off request, bumped by the tests
   int  hold_seq     = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // prediction: works out the bits one accepted edge causes
   // ------------------------------------------------------------------------
   task automatic predict_parens(input logic [elbp_pkg::NODE_BITS-1:0] parent,
                                 input logic [elbp_pkg::NODE_BITS-1:0] child,
                                 input logic last_edge);
      paren_bit_type bits [$];
      logic          fault;
      bit            matched;
      fault = 1'b0;

      // climb back up: pop until the top is the parent or the stack runs dry
      if (open_count > 0 && parent < open_stack[open_count-1]) begin
         matched = 1'b0;
         while (!matched) begin
            open_count--;
            bits = {bits, CLOSE_BIT};
            if (open_count == 0) begin
               // emptied before a match, flag the whole edge
               fault   = 1'b1;
               matched = 1'b1;
            end else if (open_stack[open_count-1] == parent) begin
               matched = 1'b1;
            end
         end
      end

      // open a new internal node, a full stack keeps nothing but still opens
      if (open_count == 0 || parent > open_stack[open_count-1]) begin
         if (open_count < elbp_pkg::STACK_DEPTH) begin
            open_stack[open_count] = parent;
            open_count++;
         end else begin
            fault = 1'b1;
         end
         bits = {bits, OPEN_BIT};
      end

      // leaf child: open then close
      if (child <= leaf_limit) begin
         bits = {bits, OPEN_BIT};
         bits = {bits, CLOSE_BIT};
      end

      // end of tree closes every open node
      if (last_edge) begin
         while (open_count > 0) begin
            open_count--;
            bits = {bits, CLOSE_BIT};
         end
      end

      if (bits.size() > 0)
         bits[bits.size()-1].run_end = 1'b1;
      foreach (bits[k]) begin
         bits[k].stack_fault = fault;
         expected_parens = {expected_parens, bits[k]};
      end
   endtask

   // ------------------------------------------------------------------------
   // result checker: every accepted bit against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      paren_bit_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_parens.size() == 0) begin
            report_mismatch($sformatf("bit %0d arrived with nothing expected", bits_seen));
         end else begin
            want = expected_parens.pop_front();
            if (rsp_paren_bit !== want.paren_bit)
               report_mismatch($sformatf("bit %0d paren_bit %b, want %b",
                                         bits_seen, rsp_paren_bit, want.paren_bit));
            if (rsp_run_end !== want.run_end)
               report_mismatch($sformatf("bit %0d run_end %b, want %b",
                                         bits_seen, rsp_run_end, want.run_end));
            if (rsp_stack_fault !== want.stack_fault)
               report_mismatch($sformatf("bit %0d stack_fault %b, want %b",
                                         bits_seen, rsp_stack_fault, want.stack_fault));
         end
         bits_seen++;
      end
   end

   // ------------------------------------------------------------------------
   // receiver: random stall patterns, plus a long hold-off on request
   // ------------------------------------------------------------------------
   int             hold_seen = 0;
   int             hold_left = 0;
   int             mode_left = 0;
   int             rx_tick   = 0;
   rx_pattern_type rx_mode   = RX_ALWAYS;

   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         // long hold-off, counted down here
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_pattern_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         rx_tick++;
         case (rx_mode)
            RX_ALWAYS:     rsp_ready <= 1'b1;
            RX_COIN:       rsp_ready <= 1'($urandom_range(0, 1));
            RX_RARE_STALL: rsp_ready <= ($urandom_range(0, 7) != 0);
            default:       rsp_ready <= (rx_tick % 3 == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------------

   // offers one edge and returns at the edge that accepts it; valid stays up
   task automatic send_edge(input logic [elbp_pkg::NODE_BITS-1:0] parent,
                            input logic [elbp_pkg::NODE_BITS-1:0] child,
                            input logic last_edge);
      req_valid       <= 1'b1;
      req_parent_node <= parent;
      req_child_node  <= child;
      req_final_edge  <= last_edge;
      do @(posedge clock); while (!req_ready);
      predict_parens(parent, child, last_edge);
      items_sent++;
   endtask

   // one edge followed, at the end of a burst, by a random gap
   task automatic send_paced(input logic [elbp_pkg::NODE_BITS-1:0] parent,
                             input logic [elbp_pkg::NODE_BITS-1:0] child,
                             input logic last_edge);
      int gap;
      send_edge(parent, child, last_edge);
      if (!steady_send) begin
         burst_left--;
         if (burst_left <= 0) begin
            // mostly short bursts, now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(1, 9);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [elbp_pkg::NODE_BITS-1:0] pick_leaf();
      // with tip_count zero only id zero is a leaf
      if (leaf_limit == 0)
         return '0;
      return elbp_pkg::NODE_BITS'($urandom_range(1, leaf_limit));
   endfunction

   // depth-first edge list of a random tree; internal ids grow with depth so
   // a climb back pops exactly the abandoned branch
   task automatic send_tree(input int n_edges, input int depth_cap,
                            input int internal_pct, input int broken_pct);
      logic [elbp_pkg::NODE_BITS-1:0] path [$];
      logic [elbp_pkg::NODE_BITS-1:0] next_id;
      logic [elbp_pkg::NODE_BITS-1:0] parent;
      logic [elbp_pkg::NODE_BITS-1:0] child;
      logic                           last_edge;
      int                             lvl;
      bit                             descend;
      if (leaf_limit < 16'd65000)
         next_id = elbp_pkg::NODE_BITS'(leaf_limit + 1 + $urandom_range(0, 50));
      else
         next_id = elbp_pkg::NODE_BITS'($urandom_range(1, 100));
      path = {path, next_id};
      next_id++;
      descend = 1'b1;
      for (int e = 0; e < n_edges; e++) begin
         // after a leaf, maybe climb back to some node on the open path
         if (!descend && $urandom_range(0, 1) == 1) begin
            lvl = $urandom_range(0, path.size() - 1);
            while (path.size() > lvl + 1)
               void'(path.pop_back());
         end
         parent    = path[$];
         last_edge = (e == n_edges - 1);
         if (path.size() < depth_cap && next_id < 16'hFFFF &&
             $urandom_range(1, 100) <= internal_pct) begin
            child = next_id;
            next_id++;
            path = {path, child};
            descend = 1'b1;
         end else begin
            child   = pick_leaf();
            descend = 1'b0;
         end
         // broken sequences: wrong parent, wrong end marker or stray child
         if ($urandom_range(1, 100) <= broken_pct) begin
            case ($urandom_range(0, 2))
               0:       parent    = elbp_pkg::NODE_BITS'($urandom_range(1, 16'hFFFF));
               1:       last_edge = ~last_edge;
               default: child     = elbp_pkg::NODE_BITS'($urandom_range(1, 16'hFFFF));
            endcase
         end
         send_paced(parent, child, last_edge);
      end
   endtask

   // idle the sender until every owed bit is in, then let the block settle
   task automatic wait_for_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_parens.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_parens.size() != 0) begin
         report_mismatch($sformatf("%0d expected bits never arrived",
                                   expected_parens.size()));
         expected_parens.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------------
   task automatic check_tip(input logic [elbp_pkg::TIP_BITS-1:0] want);
      logic [elbp_pkg::CSR_DATA_BITS-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= TIP_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got[elbp_pkg::TIP_BITS-1:0] !== want)
         report_mismatch($sformatf("tip_count reads %0d, want %0d",
                                   got[elbp_pkg::TIP_BITS-1:0], want));
   endtask

   // only called with the block idle; upper data bits are don't-care
   task automatic set_tip(input logic [elbp_pkg::TIP_BITS-1:0] value);
      wait_for_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TIP_ADDR;
      csr_pwdata  <= {16'($urandom_range(0, 16'hFFFF)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      leaf_limit = value;
      @(posedge clock);
      check_tip(value);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset value of tip_count, then a hand-built tree including an edge
   // that emits nothing
   task automatic test_small_tree();
      check_tip(elbp_pkg::TIP_COUNT_RESET);
      // only nodes 0 and 1 are leaves after reset
      send_paced(3, 2, 1'b0);
      send_paced(3, 1, 1'b1);
      set_tip(3);
      send_paced(4, 5, 1'b0);   // push 4
      send_paced(4, 6, 1'b0);   // parent is top, child internal: no bits
      send_paced(5, 1, 1'b0);   // push 5, leaf
      send_paced(5, 2, 1'b0);   // leaf only
      send_paced(4, 3, 1'b1);   // climb to 4, leaf, close all
   endtask

   // largest ids and tip_count at both ends, including zero
   task automatic test_id_extremes();
      set_tip(16'hFFFF);
      send_paced(16'hFFFF, 16'hFFFF, 1'b0);
      send_paced(1, 1, 1'b0);              // below top, stack runs dry
      send_paced(1, 16'hFFFF, 1'b1);
      set_tip(0);
      send_paced(2, 0, 1'b0);              // child zero is the only leaf
      send_paced(2, 1, 1'b1);
   endtask

   // parent not on the stack: pops until empty, then pushes it
   task automatic test_empty_before_match();
      set_tip(10);
      send_paced(20, 1, 1'b0);
      send_paced(30, 2, 1'b0);
      send_paced(25, 3, 1'b0);
      send_paced(25, 4, 1'b1);
   endtask

   // a path deeper than the stack, closed by the final edge
   task automatic test_stack_overflow();
      set_tip(1);
      send_tree(45, 60, 92, 0);
   endtask

   // receiver holds off while the sender keeps offering, so the block
   // backs up and stalls its input; then the sender waits for all bits
   task automatic test_backpressure();
      wait_for_results();
      steady_send = 1'b1;
      hold_seq++;
      send_tree(30, 8, 50, 0);
      steady_send = 1'b0;
      wait_for_results();
   endtask

   // random trees and noise under several tip_count settings
   task automatic test_random_trees();
      int target;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       set_tip(1);
            1:       set_tip(16'hFFFF);
            2:       set_tip(0);
            3:       set_tip(5);
            default: set_tip(elbp_pkg::TIP_BITS'($urandom_range(2, 60000)));
         endcase
         target = items_sent + 37;
         while (items_sent < target) begin
            if ($urandom_range(1, 10) <= 8) begin
               // well-formed trees, mostly small, some with broken edges
               send_tree(($urandom_range(0, 7) == 0) ? $urandom_range(13, 25)
                                                     : $urandom_range(1, 8),
                         10, 50, 10);
            end else begin
               send_paced(elbp_pkg::NODE_BITS'($urandom_range(1, 16'hFFFF)),
                          ($urandom_range(0, 1) == 1) ?
                             pick_leaf() :
                             elbp_pkg::NODE_BITS'($urandom_range(1, 16'hFFFF)),
                          ($urandom_range(0, 5) == 0));
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // run
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_small_tree();
      test_id_extremes();
      test_empty_before_match();
      test_stack_overflow();
      test_backpressure();
      test_random_trees();

      wait_for_results();
      if (error_count == 0)
         $display("[edge_list_to_balanced_parens] OK");
      else
         $display("[edge_list_to_balanced_parens] ERROR");
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin
      #4000000;
      $display("[edge_list_to_balanced_parens] ERROR");
      $finish;
   end

endmodule

// File: edge_list_to_balanced_parens.f
rtl/core/elbp_pkg.sv
rtl/core/elbp_front.sv
rtl/core/elbp_queue.sv
rtl/core/elbp_back.sv
rtl/core/edge_list_to_balanced_parens.sv
tb/tb_edge_list_to_balanced_parens.sv
